// ===== rtl/windowed_rsi_indicator_core_defines.svh =====
// assertion macros shared by the rsi core modules
// expects signals clk and arst_n in the including module
`ifndef WINDOWED_RSI_INDICATOR_CORE_DEFINES_SVH
`define WINDOWED_RSI_INDICATOR_CORE_DEFINES_SVH

// property checked at every rising clock edge outside reset
`define RSI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define RSI_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rsi_pkg.sv =====
// shared types and constants of the windowed rsi core
// no dependencies
`default_nettype none

package rsi_pkg;

	localparam int CFG_W     = 7;
	localparam int CFG_RESET = 14;
	localparam int IN_W      = 32;
	localparam int RSI_W     = 23;

	// 100 and 50 in q7.16
	localparam logic [RSI_W-1:0] RSI_SCALE = 23'd6553600;
	localparam logic [RSI_W-1:0] RSI_HALF  = 23'd3276800;

	// what the front part decided about one item
	typedef struct packed {
		logic has_change;
		logic evict;
		logic neg;
		logic full;
	} cmd_ctl_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_READ,
		BK_ADD,
		BK_EVAL,
		BK_DIV,
		BK_HOLD
	} bk_state_t;

endpackage

`default_nettype wire

// ===== rtl/rsi_front.sv =====
// front part: window length register, price history count, change classification
// depends on rsi_pkg
`default_nettype none

module rsi_front
	import rsi_pkg::*;
#(
	parameter int MAX_WINDOW = 64,
	parameter int PRICE_BITS = 32,
	localparam int LEN_W = $clog2(MAX_WINDOW + 1),
	localparam int CNT_W = $clog2(MAX_WINDOW + 2),
	localparam int PTR_W = $clog2(MAX_WINDOW)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_W-1:0]      cfg_wr_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [IN_W-1:0]       close_price,
	input  wire logic                  restart,
	input  wire logic                  fifo_full,
	output logic                       push,
	output cmd_ctl_t                   push_ctl,
	output logic [PTR_W-1:0]           push_ptr,
	output logic [PRICE_BITS-1:0]      push_mag
);

	logic [LEN_W-1:0]      len_q;
	logic [PRICE_BITS-1:0] prev_q;
	logic [PRICE_BITS-1:0] price;
	logic [CNT_W-1:0]      seen_q, seen, seen_nx, lim;
	logic [PTR_W-1:0]      ptr_q, ptr, ptr_nx;
	logic [LEN_W-1:0]      ptr_inc;

	function automatic logic [LEN_W-1:0] clamp_len(input logic [CFG_W-1:0] v);
		logic [LEN_W-1:0] r;
		if (v == '0) begin
			r = LEN_W'(1);
		end else if (int'(v) > MAX_WINDOW) begin
			r = LEN_W'(MAX_WINDOW);
		end else begin
			r = LEN_W'(v);
		end
		return r;
	endfunction

	assign in_ready = !fifo_full;
	assign push     = in_valid && !fifo_full;

	always_comb begin
		price   = PRICE_BITS'(close_price);
		seen    = restart ? '0 : seen_q;
		ptr     = restart ? '0 : ptr_q;
		lim     = CNT_W'(len_q) + CNT_W'(1);
		seen_nx = (seen < lim) ? seen + CNT_W'(1) : seen;
		ptr_inc = LEN_W'(ptr) + LEN_W'(1);

		push_ctl.has_change = (seen != '0);
		// the oldest change leaves once the ring already holds len of them
		push_ctl.evict      = (seen >= lim);
		push_ctl.neg        = (price < prev_q);
		push_ctl.full       = (seen_nx >= lim);
		push_mag            = push_ctl.neg ? prev_q - price : price - prev_q;
		push_ptr            = ptr;

		if (!push_ctl.has_change) begin
			ptr_nx = ptr;
		end else if (ptr_inc >= len_q) begin
			ptr_nx = '0;
		end else begin
			ptr_nx = PTR_W'(ptr_inc);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= clamp_len(CFG_W'(CFG_RESET));
			seen_q <= '0;
			ptr_q  <= '0;
		end else if (cfg_wr_en) begin
			// a new window length drops the history
			len_q  <= clamp_len(cfg_wr_data);
			seen_q <= '0;
			ptr_q  <= '0;
		end else if (push) begin
			seen_q <= seen_nx;
			ptr_q  <= ptr_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			prev_q <= price;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rsi_fifo.sv =====
// short command queue between the front and back parts
// depends on the assertion macro header
`default_nettype none

`include "windowed_rsi_indicator_core_defines.svh"

module rsi_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2,
	localparam int AW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] wr_data,
	input  wire logic         pop,
	output logic [W-1:0]      rd_data,
	output logic              empty,
	output logic              full
);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CW'(DEPTH));
	assign rd_data = mem_q[rd_ptr_q];

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
		logic [AW-1:0] r;
		if (p == AW'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + AW'(1);
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	`RSI_ASSERT(a_no_pop_empty, pop |-> !empty, "queue popped while empty")
	`RSI_ASSERT(a_no_push_full, push |-> !full, "queue pushed while full")
	`RSI_ASSERT_NXT(a_push_fills, push && !pop, !empty, "queue lost a pushed command")

endmodule

`default_nettype wire

// ===== rtl/rsi_div.sv =====
// bit-serial scaled ratio unit: floor(gain * 6553600 / total), one quotient bit a cycle
// depends on rsi_pkg
`default_nettype none

module rsi_div
	import rsi_pkg::*;
#(
	parameter int SUM_W = 39,
	localparam int R_W = SUM_W + 3,
	localparam int N_W = $clog2(RSI_W)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [SUM_W-1:0] gain,
	input  wire logic [SUM_W:0]   total,
	output logic                  done,
	output logic [RSI_W-1:0]      quot
);

	logic             busy_q, done_q;
	logic [N_W-1:0]   cnt_q;
	logic [SUM_W-1:0] g_q;
	logic [SUM_W:0]   t_q;
	logic [R_W-1:0]   r_q, s, t1, t2, r_nx;
	logic [RSI_W-1:0] q_q, q_nx;
	logic [1:0]       k;

	// remainder stays below total, so at most two subtractions per bit
	always_comb begin
		s  = {r_q[R_W-2:0], 1'b0} + (RSI_SCALE[cnt_q] ? R_W'(g_q) : '0);
		t1 = R_W'(t_q);
		t2 = R_W'({t_q, 1'b0});
		if (s >= t2) begin
			r_nx = s - t2;
			k    = 2'd2;
		end else if (s >= t1) begin
			r_nx = s - t1;
			k    = 2'd1;
		end else begin
			r_nx = s;
			k    = 2'd0;
		end
		q_nx = {q_q[RSI_W-2:0], 1'b0} + RSI_W'(k);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			g_q   <= gain;
			t_q   <= total;
			r_q   <= '0;
			q_q   <= '0;
			cnt_q <= N_W'(RSI_W - 1);
		end else if (busy_q) begin
			r_q   <= r_nx;
			q_q   <= q_nx;
			cnt_q <= cnt_q - N_W'(1);
		end
	end

	assign done = done_q;
	assign quot = q_q;

endmodule

`default_nettype wire

// ===== rtl/rsi_back.sv =====
// back part: change ring, running gain and loss sums, rsi evaluation, output register
// depends on rsi_pkg, rsi_div and the assertion macro header
`default_nettype none

`include "windowed_rsi_indicator_core_defines.svh"

module rsi_back
	import rsi_pkg::*;
#(
	parameter int MAX_WINDOW = 64,
	parameter int PRICE_BITS = 32,
	localparam int PTR_W = $clog2(MAX_WINDOW),
	localparam int SUM_W = PRICE_BITS + $clog2(MAX_WINDOW + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  fifo_empty,
	output logic                       fifo_pop,
	input  wire cmd_ctl_t              cmd_ctl,
	input  wire logic [PTR_W-1:0]      cmd_ptr,
	input  wire logic [PRICE_BITS-1:0] cmd_mag,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [RSI_W-1:0]           rsi_value,
	output logic                       window_full
);

	bk_state_t state_q, state_nx;

	cmd_ctl_t              ctl_q;
	logic [PTR_W-1:0]      ptr_q;
	logic [PRICE_BITS-1:0] mag_q;
	logic [PRICE_BITS:0]   ring [MAX_WINDOW];
	logic [PRICE_BITS:0]   old_q;
	logic [SUM_W-1:0]      gain_q, loss_q;
	logic [RSI_W-1:0]      res_q, div_q;
	logic                  need_div, div_start, div_done, out_free, out_load;
	logic                  out_valid_q, out_full_q;
	logic [RSI_W-1:0]      out_rsi_q;

	assign need_div = ctl_q.full && (gain_q != '0) && (loss_q != '0);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!fifo_empty) begin
					state_nx = BK_READ;
				end
			end
			BK_READ: state_nx = BK_ADD;
			BK_ADD:  state_nx = BK_EVAL;
			BK_EVAL: state_nx = need_div ? BK_DIV : BK_HOLD;
			BK_DIV: begin
				if (div_done) begin
					state_nx = BK_HOLD;
				end
			end
			BK_HOLD: begin
				if (out_free) begin
					state_nx = BK_IDLE;
				end
			end
			default: state_nx = BK_IDLE;
		endcase
	end

	always_comb begin
		fifo_pop  = (state_q == BK_IDLE) && !fifo_empty;
		div_start = (state_q == BK_EVAL) && need_div;
		out_load  = (state_q == BK_HOLD) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ring entries carry the sign in the top bit
	always_ff @(posedge clk) begin
		if (fifo_pop) begin
			old_q <= ring[cmd_ptr];
		end
		if (state_q == BK_ADD && ctl_q.has_change) begin
			ring[ptr_q] <= {ctl_q.neg, mag_q};
		end
	end

	always_ff @(posedge clk) begin
		if (fifo_pop) begin
			ctl_q <= cmd_ctl;
			ptr_q <= cmd_ptr;
			mag_q <= cmd_mag;
		end

		// first item of a series starts from empty sums
		if (state_q == BK_READ) begin
			if (!ctl_q.has_change) begin
				gain_q <= '0;
				loss_q <= '0;
			end else if (ctl_q.evict) begin
				if (old_q[PRICE_BITS]) begin
					loss_q <= loss_q - SUM_W'(old_q[PRICE_BITS-1:0]);
				end else begin
					gain_q <= gain_q - SUM_W'(old_q[PRICE_BITS-1:0]);
				end
			end
		end

		if (state_q == BK_ADD && ctl_q.has_change) begin
			if (ctl_q.neg) begin
				loss_q <= loss_q + SUM_W'(mag_q);
			end else begin
				gain_q <= gain_q + SUM_W'(mag_q);
			end
		end

		if (state_q == BK_EVAL) begin
			if (!ctl_q.full) begin
				res_q <= RSI_HALF;
			end else if (gain_q == '0) begin
				res_q <= '0;
			end else begin
				res_q <= RSI_SCALE;
			end
		end else if (state_q == BK_DIV && div_done) begin
			res_q <= div_q;
		end

		if (out_load) begin
			out_rsi_q  <= res_q;
			out_full_q <= ctl_q.full;
		end
	end

	rsi_div #(
		.SUM_W(SUM_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.gain  (gain_q),
		.total ({1'b0, gain_q} + {1'b0, loss_q}),
		.done  (div_done),
		.quot  (div_q)
	);

	assign out_valid   = out_valid_q;
	assign rsi_value   = out_rsi_q;
	assign window_full = out_full_q;

	`RSI_ASSERT(a_rsi_range, out_valid_q |-> out_rsi_q <= RSI_SCALE, "rsi above 100")
	`RSI_ASSERT(a_default_half, out_valid_q && !out_full_q |-> out_rsi_q == RSI_HALF, "partial window not 50")
	`RSI_ASSERT(a_div_owned, div_done |-> state_q == BK_DIV, "divider finished outside divide state")
	`RSI_ASSERT_NXT(a_pop_reads, fifo_pop, state_q == BK_READ, "popped command not taken up")

endmodule

`default_nettype wire

// ===== rtl/windowed_rsi_indicator_core.sv =====
// windowed rsi core top level: front classifier, two-entry command queue, back evaluator
// an item passes the front into the queue; the back pops it, then reads, adds, evaluates, divides if needed, holds
// the back pops a new item only once its held result is loaded; the divide makes 23 quotient bits, one a cycle
// the front takes up to two more items while the back works or the result waits
// reset: arst_n clears control state, window length returns to 14, history is empty
`default_nettype none

module windowed_rsi_indicator_core
	import rsi_pkg::*;
#(
	parameter int MAX_WINDOW = 64,
	parameter int PRICE_BITS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [CFG_W-1:0]  cfg_wr_data,    // window_length
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [IN_W-1:0]   s_axis_tdata,   // close_price
	input  wire logic [0:0]        s_axis_tuser,   // restart
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic [23:0]            m_axis_tdata,   // rsi_value, then one zero bit
	output logic [0:0]             m_axis_tuser    // window_full
);

	localparam int PTR_W = $clog2(MAX_WINDOW);
	localparam int CMD_W = $bits(cmd_ctl_t) + PTR_W + PRICE_BITS;

	cmd_ctl_t              push_ctl, pop_ctl;
	logic [PTR_W-1:0]      push_ptr, pop_ptr;
	logic [PRICE_BITS-1:0] push_mag, pop_mag;
	logic [CMD_W-1:0]      push_data, pop_data;
	logic                  push, pop, fifo_empty, fifo_full;
	logic [RSI_W-1:0]      rsi_value;
	logic                  window_full;

	rsi_front #(
		.MAX_WINDOW(MAX_WINDOW),
		.PRICE_BITS(PRICE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.close_price(s_axis_tdata),
		.restart    (s_axis_tuser[0]),
		.fifo_full  (fifo_full),
		.push       (push),
		.push_ctl   (push_ctl),
		.push_ptr   (push_ptr),
		.push_mag   (push_mag)
	);

	assign push_data = {push_ctl, push_ptr, push_mag};
	assign {pop_ctl, pop_ptr, pop_mag} = pop_data;

	rsi_fifo #(
		.W    (CMD_W),
		.DEPTH(2)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_data(push_data),
		.pop    (pop),
		.rd_data(pop_data),
		.empty  (fifo_empty),
		.full   (fifo_full)
	);

	rsi_back #(
		.MAX_WINDOW(MAX_WINDOW),
		.PRICE_BITS(PRICE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_empty (fifo_empty),
		.fifo_pop   (pop),
		.cmd_ctl    (pop_ctl),
		.cmd_ptr    (pop_ptr),
		.cmd_mag    (pop_mag),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.rsi_value  (rsi_value),
		.window_full(window_full)
	);

	assign m_axis_tdata = {1'b0, rsi_value};
	assign m_axis_tuser = window_full;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// self-checking testbench for windowed_rsi_indicator_core
// depends on rsi_pkg and the core rtl, predicts every rsi value and compares in order
`default_nettype none

module tb;
	import rsi_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_WIN     = 64;
	localparam int CYCLE_LIMIT = 300000;
	localparam int IDLE_PCT    = 24;
	localparam logic [63:0] SCALE_WIDE = 64'd6553600;

	typedef struct packed {
		logic [RSI_W-1:0] rsi;
		logic             full;
	} rsi_result_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_wr_en;
	logic [CFG_W-1:0]  cfg_wr_data;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata;   // close_price
	logic [0:0]        s_axis_tuser;   // restart
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [23:0]       m_axis_tdata;   // rsi_value, then one zero pad bit
	logic [0:0]        m_axis_tuser;   // window_full

	// predictor state
	logic [CFG_W-1:0]  window_reg;
	logic [IN_W-1:0]   last_close;
	logic              ring_neg [MAX_WIN];
	logic [IN_W-1:0]   ring_mag [MAX_WIN];
	int unsigned       ring_idx;
	logic [37:0]       up_sum;
	logic [37:0]       down_sum;
	int unsigned       closes_seen;

	rsi_result_t       pending_rsi [$];
	logic [IN_W-1:0]   walk_close;
	bit                no_gaps;
	int                errors;
	int                prices_sent;
	int                results_checked;
	int                full_checked;
	int                window_settings;
	int                cycles;

	windowed_rsi_indicator_core #(
		.MAX_WINDOW(MAX_WIN),
		.PRICE_BITS(32)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, pending_rsi.size());
			$display("tb failed");
			$finish;
		end
	end

	function automatic int unsigned window_in_use();
		if (window_reg == 0)
			return 1;
		if (window_reg > MAX_WIN)
			return MAX_WIN;
		return {25'd0, window_reg};
	endfunction

	function automatic void clear_history();
		ring_idx    = 0;
		up_sum      = '0;
		down_sum    = '0;
		closes_seen = 0;
	endfunction

	// one close price in, one expected rsi out
	function automatic rsi_result_t advance_rsi_model(logic [IN_W-1:0] close, logic restart);
		int unsigned wl;
		int unsigned p;
		logic        neg;
		logic [IN_W-1:0] mag;
		logic [63:0] total;
		rsi_result_t res;
		wl = window_in_use();
		res.rsi  = RSI_HALF;
		res.full = 1'b0;
		if (restart)
			clear_history();
		if (closes_seen > 0) begin
			neg = close < last_close;
			mag = neg ? last_close - close : close - last_close;
			p = (ring_idx >= wl) ? 0 : ring_idx;
			// oldest change leaves the window once it is full
			if (closes_seen - 1 >= wl) begin
				if (ring_neg[p])
					down_sum -= 38'(ring_mag[p]);
				else
					up_sum -= 38'(ring_mag[p]);
			end
			ring_neg[p] = neg;
			ring_mag[p] = mag;
			if (neg)
				down_sum += 38'(mag);
			else
				up_sum += 38'(mag);
			p++;
			ring_idx = (p >= wl) ? 0 : p;
		end
		last_close = close;
		if (closes_seen < wl + 1)
			closes_seen++;
		if (closes_seen >= wl + 1) begin
			res.full = 1'b1;
			if (up_sum == 0)
				res.rsi = '0;
			else if (down_sum == 0)
				res.rsi = RSI_SCALE;
			else begin
				total = 64'(up_sum) + 64'(down_sum);
				res.rsi = RSI_W'((64'(up_sum) * SCALE_WIDE) / total);
			end
		end
		return res;
	endfunction

	// called at a falling edge, returns at a falling edge with the transaction done
	task automatic send_close(input logic [IN_W-1:0] close, input logic restart);
		while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= close;
		s_axis_tuser  <= restart;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_rsi.insert(pending_rsi.size(), advance_rsi_model(close, restart));
		prices_sent++;
		walk_close = close;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_rsi.size() != 0)
			@(negedge clk);
	endtask

	// block must be idle here
	task automatic write_window(input logic [CFG_W-1:0] len);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= len;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		window_reg = len;
		clear_history();
		window_settings++;
	endtask

	always @(negedge clk) begin
		if (no_gaps)
			m_axis_tready <= 1'b1;
		else
			m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		rsi_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_rsi.size() == 0) begin
				$display("%0t: unexpected result, expected none actual rsi %0d full %0b",
					$time, m_axis_tdata[RSI_W-1:0], m_axis_tuser[0]);
				errors++;
			end else begin
				want = pending_rsi.pop_front();
				results_checked++;
				if (want.full)
					full_checked++;
				if (m_axis_tdata[RSI_W-1:0] !== want.rsi) begin
					$display("%0t: rsi_value mismatch, expected %0d actual %0d",
						$time, want.rsi, m_axis_tdata[RSI_W-1:0]);
					errors++;
				end
				if (m_axis_tuser[0] !== want.full) begin
					$display("%0t: window_full mismatch, expected %0b actual %0b",
						$time, want.full, m_axis_tuser[0]);
					errors++;
				end
				if (m_axis_tdata[23] !== 1'b0) begin
					$display("%0t: tdata pad bit mismatch, expected 0 actual %b",
						$time, m_axis_tdata[23]);
					errors++;
				end
			end
		end
	end

	// reset value of the window gives 50 until the window fills
	task automatic test_default_window();
		send_close(32'd1000, 1'b0);
		send_close(32'd1010, 1'b0);
		send_close(32'd990, 1'b1);
		wait_drained();
	endtask

	task automatic test_special_cases();
		write_window(7'd2);
		send_close(32'd0, 1'b1);
		send_close(32'd0, 1'b0);           // zero change
		send_close(32'd0, 1'b0);           // no gain and no loss
		send_close(32'hFFFF_FFFF, 1'b0);   // gain with no loss
		send_close(32'hFFFF_FFFF, 1'b0);
		send_close(32'd0, 1'b0);           // loss only
		send_close(32'd5, 1'b0);           // tiny gain against full loss
		send_close(32'd3, 1'b1);           // restart drops back to 50
		send_close(32'd7, 1'b0);
		send_close(32'd1, 1'b0);
		wait_drained();
	endtask

	// zero acts as a window of one
	task automatic test_window_clamp();
		write_window(7'd0);
		send_close(32'd10, 1'b0);
		send_close(32'd20, 1'b0);
		send_close(32'd5, 1'b0);
		send_close(32'd5, 1'b0);
		wait_drained();
	endtask

	task automatic test_random_series();
		int windows [10] = '{7, 64, 1, 127, 20, 65, 3, 0, 40, 2};
		int count;
		int pick;
		logic [IN_W-1:0] close;
		for (int ph = 0; ph < 10; ph++) begin
			write_window(CFG_W'(windows[ph]));
			no_gaps = (ph == 1);
			count = (windows[ph] >= 40) ? 70 : 25;
			walk_close = $urandom;
			for (int i = 0; i < count; i++) begin
				pick = $urandom_range(99);
				if (pick < 70)
					close = walk_close + IN_W'($urandom_range(2000)) - IN_W'(1000);
				else if (pick < 80)
					close = $urandom;
				else if (pick < 90)
					close = walk_close;
				else
					close = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
				send_close(close, $urandom_range(59) == 0);
			end
			wait_drained();
			no_gaps = 1'b0;
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		cfg_wr_en       = 1'b0;
		cfg_wr_data     = '0;
		s_axis_tvalid   = 1'b0;
		s_axis_tdata    = '0;
		s_axis_tuser    = '0;
		m_axis_tready   = 1'b0;
		no_gaps         = 1'b0;
		errors          = 0;
		prices_sent     = 0;
		results_checked = 0;
		full_checked    = 0;
		window_settings = 0;
		cycles          = 0;
		walk_close      = '0;
		window_reg      = CFG_W'(CFG_RESET);
		last_close      = '0;
		clear_history();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_default_window();
		test_special_cases();
		test_window_clamp();
		test_random_series();

		repeat (40) @(negedge clk);
		$display("covered %0d close prices over %0d window settings plus the reset default",
			prices_sent, window_settings);
		$display("checked %0d results, %0d of them with a full window",
			results_checked, full_checked);
		if (errors == 0 && pending_rsi.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

`default_nettype wire
